@@ rtl/core/sih_pkg.sv @@
`timescale 1ns / 1ps
package sih_pkg;

  localparam int KEY_LOW_W  = 64;
  localparam int KEY_HIGH_W = 56;
  localparam int LEN_W      = 4;
  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int LIMIT_W    = 11;

  localparam int MAX_ENTRIES = 1024;
  localparam int NUM_BUCKETS = 2048;

  localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FN_INTERN = 2'd1;
  localparam logic [FUNC_W-1:0] FN_READ   = 2'd2;
  localparam logic [FUNC_W-1:0] FN_NONE   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

  localparam logic [63:0] MIX_C0 = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_C1 = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_C2 = 64'h94D049BB133111EB;

  // 32x32 partial product
  function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
    mul32 = {32'd0, a} * {32'd0, b};
  endfunction

endpackage

@@ rtl/core/sih_if.sv @@
`timescale 1ns / 1ps
interface sih_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] key_low;
  logic [55:0] key_high;
  logic [3:0]  key_length;
  logic [9:0]  symbol_id;
  modport source (output valid, func, key_low, key_high, key_length, symbol_id, input ready);
  modport sink (input valid, func, key_low, key_high, key_length, symbol_id, output ready);
endinterface

interface sih_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [9:0]  result_id;
  logic [63:0] name_low;
  logic [55:0] name_high;
  logic [3:0]  name_length;
  modport source (output valid, status, result_id, name_low, name_high, name_length,
                  input ready);
  modport sink (input valid, status, result_id, name_low, name_high, name_length,
                output ready);
endinterface

@@ rtl/core/sih_ram.sv @@
`timescale 1ns / 1ps
module sih_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/sih_front.sv @@
`timescale 1ns / 1ps
// Accepts items, masks the key and, for lookups and interns, computes the bucket hash
// with one 32x32 multiplier, then pushes a job into the queue.
module sih_front (
  input  logic           clk,
  input  logic           rst_n,
  sih_in_if.sink         in_ch,
  output logic           job_valid,
  input  logic           job_ready,
  output logic [1:0]     job_func,
  output logic [63:0]    job_lo,
  output logic [63:0]    job_hi,
  output logic [9:0]     job_sid,
  output logic [63:0]    job_hash
);
  import sih_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL  = 4'b0010,
    F_PUSH = 4'b0100,
    F_SKIP = 4'b1000
  } fstate_t;

  fstate_t     st_r, st_nxt;
  logic [1:0]  func_r;
  logic [63:0] lo_r, hi_r, m_r, acc_r, a_r, b_r;
  logic [9:0]  sid_r;
  logic [4:0]  step_r;
  logic [63:0] lo_m, hi_m;
  logic [63:0] pp;
  logic [31:0] pa, pb;

  always_comb begin
    logic [3:0] l;
    l = in_ch.key_length;
    lo_m = in_ch.key_low;
    hi_m = {8'd0, in_ch.key_high};
    for (int i = 0; i < 8; i++) if (4'(i) >= l) lo_m[i*8 +: 8] = 8'd0;
    for (int i = 0; i < 7; i++) if (4'(i + 8) >= l) hi_m[i*8 +: 8] = 8'd0;
    hi_m[63:56] = {4'd0, l};
  end

  // Multiply a_r*b_r (low 64 bits) over three partial products.
  always_comb begin
    case (step_r[1:0])
      2'd0:    begin pa = a_r[31:0];  pb = b_r[31:0];  end
      2'd1:    begin pa = a_r[63:32]; pb = b_r[31:0];  end
      default: begin pa = a_r[31:0];  pb = b_r[63:32]; end
    endcase
    pp = mul32(pa, pb);
  end

  assign in_ch.ready = (st_r == F_IDLE);
  assign job_valid   = (st_r == F_PUSH) || (st_r == F_SKIP);
  assign job_func    = func_r;
  assign job_lo      = lo_r;
  assign job_hi      = hi_r;
  assign job_sid     = sid_r;
  assign job_hash    = m_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      F_IDLE:  if (in_ch.valid) st_nxt = (in_ch.func == FN_LOOKUP || in_ch.func == FN_INTERN)
                                           ? F_MUL : F_SKIP;
      F_MUL:   if (step_r == 5'd10) st_nxt = F_PUSH;
      F_PUSH,
      F_SKIP:  if (job_ready) st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  // step[4:2] = multiply phase, step[1:0] = partial product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
      step_r <= 5'd0;
    end else begin
      st_r <= st_nxt;
      if (st_r == F_IDLE) step_r <= 5'd0;
      else if (st_r == F_MUL) step_r <= (step_r[1:0] == 2'd2) ? step_r + 5'd2 : step_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    logic [63:0] prod, t;
    if (st_r == F_IDLE && in_ch.valid) begin
      func_r <= in_ch.func;
      lo_r   <= lo_m;
      hi_r   <= hi_m;
      sid_r  <= in_ch.symbol_id;
      a_r    <= lo_m ^ MIX_C0;
      b_r    <= MIX_C1;
    end else if (st_r == F_MUL) begin
      case (step_r[1:0])
        2'd0:    acc_r <= pp;
        2'd1:    acc_r <= acc_r + {pp[31:0], 32'd0};
        default: begin
          prod = acc_r + {pp[31:0], 32'd0};
          case (step_r[4:2])
            3'd0: begin
              m_r <= prod ^ (prod >> 31);
              a_r <= hi_r; b_r <= MIX_C2;
            end
            3'd1: begin
              t = m_r ^ prod;
              t = t ^ (t >> 29);
              a_r <= t; b_r <= MIX_C1;
            end
            default: m_r <= prod ^ (prod >> 32);
          endcase
        end
      endcase
    end
  end
endmodule

@@ rtl/core/sih_back.sv @@
`timescale 1ns / 1ps
// Probes buckets one at a time, compares names, inserts and reads back.
// A bucket entry holds {used, id}; used bits are cleared by a clearing pass and set on insert.
module sih_back (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [10:0] entry_limit,
  output logic        clearing,
  input  logic        job_valid,
  output logic        job_ready,
  input  logic [1:0]  job_func,
  input  logic [63:0] job_lo,
  input  logic [63:0] job_hi,
  input  logic [9:0]  job_sid,
  input  logic [63:0] job_hash,
  sih_out_if.source   out_ch
);
  import sih_pkg::*;

  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int EW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = (CW > LIMIT_W) ? CW : LIMIT_W;

  typedef enum logic [7:0] {
    B_CLR   = 8'b00000001,
    B_IDLE  = 8'b00000010,
    B_BRD   = 8'b00000100,
    B_BCHK  = 8'b00001000,
    B_NCHK  = 8'b00010000,
    B_NRD   = 8'b00100000,
    B_OUT   = 8'b01000000,
    B_WAIT  = 8'b10000000
  } bstate_t;

  bstate_t st_r, st_nxt;
  logic [BW-1:0] slot_r, clr_r;
  logic [BW:0]   probes_r;
  logic [CW-1:0] count_r;
  logic [1:0]    func_r;
  logic [63:0]   lo_r, hi_r;
  logic [9:0]    sid_r;
  logic [2:0]    o_status_r;
  logic [9:0]    o_id_r;
  logic [63:0]   o_lo_r, o_hi_r;

  logic          b_we;
  logic [BW-1:0] b_waddr, b_raddr;
  logic [EW:0]   b_wdata, b_rdata;
  logic          n_we;
  logic [EW-1:0] n_waddr, n_raddr;
  logic [63:0]   nl_rdata, nh_rdata;

  sih_ram #(.WIDTH(EW + 1), .DEPTH(NUM_BUCKETS)) u_bkt (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(b_raddr), .rdata(b_rdata));
  sih_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES)) u_nlo (
    .clk, .we(n_we), .waddr(n_waddr), .wdata(lo_r), .raddr(n_raddr), .rdata(nl_rdata));
  sih_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES)) u_nhi (
    .clk, .we(n_we), .waddr(n_waddr), .wdata(hi_r), .raddr(n_raddr), .rdata(nh_rdata));

  logic [IW-1:0] lim;
  logic          sid_ok;
  logic [EW-1:0] cand;
  always_comb begin
    lim = IW'(entry_limit);
    if (lim < IW'(2)) lim = IW'(2);
    if (lim > IW'(MAX_ENTRIES)) lim = IW'(MAX_ENTRIES);
    sid_ok = ({22'd0, sid_r} < 32'(count_r)) && ({22'd0, sid_r} < 32'(MAX_ENTRIES));
    cand = b_rdata[EW-1:0];
  end

  assign clearing  = (st_r == B_CLR);
  assign job_ready = (st_r == B_IDLE);
  assign b_raddr   = slot_r;
  assign n_raddr   = (st_r == B_NRD || st_r == B_IDLE) ? EW'(sid_r) : cand;
  assign n_waddr   = count_r[EW-1:0];

  always_comb begin
    b_we = 1'b0; b_waddr = clr_r; b_wdata = '0; n_we = 1'b0;
    if (st_r == B_CLR) b_we = 1'b1;
    else if (st_r == B_BCHK && func_r == FN_INTERN && !b_rdata[EW] && 32'(count_r) < 32'(lim))
    begin
      b_we = 1'b1; b_waddr = slot_r; b_wdata = {1'b1, count_r[EW-1:0]}; n_we = 1'b1;
    end
  end

  assign out_ch.valid       = (st_r == B_WAIT);
  assign out_ch.status      = o_status_r;
  assign out_ch.result_id   = o_id_r;
  assign out_ch.name_low    = o_lo_r;
  assign out_ch.name_high   = o_hi_r[55:0];
  assign out_ch.name_length = o_hi_r[59:56];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_CLR; clr_r <= '0; count_r <= '0;
    end else begin
      case (st_r)
        B_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == BW'(NUM_BUCKETS - 1)) st_r <= B_IDLE;
        end
        B_IDLE: if (job_valid) begin
          func_r <= job_func; lo_r <= job_lo; hi_r <= job_hi; sid_r <= job_sid;
          slot_r <= job_hash[BW-1:0]; probes_r <= '0;
          o_status_r <= ST_NOT_FOUND; o_id_r <= '0; o_lo_r <= '0; o_hi_r <= '0;
          if (job_func == FN_LOOKUP || job_func == FN_INTERN) st_r <= B_BRD;
          else if (job_func == FN_READ) st_r <= B_NRD;
          else st_r <= B_WAIT;
        end
        B_BRD: st_r <= B_BCHK;
        B_BCHK: begin
          if (!b_rdata[EW]) begin
            st_r <= B_WAIT;
            if (func_r == FN_INTERN) begin
              if (32'(count_r) < 32'(lim)) begin
                o_status_r <= ST_INSERTED; o_id_r <= 10'(count_r);
                count_r <= count_r + 1'b1;
              end else o_status_r <= ST_FULL;
            end
          end else st_r <= B_NCHK;
        end
        B_NCHK: begin
          if (nl_rdata == lo_r && nh_rdata == hi_r) begin
            o_status_r <= ST_FOUND; o_id_r <= 10'(cand); st_r <= B_WAIT;
          end else if (probes_r == (BW+1)'(NUM_BUCKETS - 1)) begin
            o_status_r <= (func_r == FN_INTERN) ? ST_FULL : ST_NOT_FOUND; st_r <= B_WAIT;
          end else begin
            probes_r <= probes_r + 1'b1; slot_r <= slot_r + 1'b1; st_r <= B_BRD;
          end
        end
        B_NRD: st_r <= B_OUT;
        B_OUT: begin
          if (sid_ok) begin
            o_status_r <= ST_FOUND; o_id_r <= sid_r; o_lo_r <= nl_rdata; o_hi_r <= nh_rdata;
          end else o_status_r <= ST_RANGE;
          st_r <= B_WAIT;
        end
        B_WAIT: if (out_ch.ready) st_r <= B_IDLE;
        default: st_r <= B_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(MAX_ENTRIES)) else $error("entry count overflow");
  a_insert_inc: assert property (@(posedge clk) disable iff (!rst_n)
    n_we && st_r == B_BCHK |=> count_r == $past(count_r) + 1'b1) else $error("insert lost");
  a_no_job_clr: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !job_ready) else $error("job taken during clear");
`endif
endmodule

@@ rtl/core/symbol_intern_hash_table_top.sv @@
`timescale 1ns / 1ps
// Lookup or intern: the front hashes the key in three 64-bit multiplies of 3 partial
// products each, then the back probes buckets in turn (read bucket, check it, check the
// name); a name read skips hashing and probing.
// Throughput: one item in flight per side; front hashes the next while back probes.
// Reset: synchronous active low; a clearing pass then writes all NUM_BUCKETS (2048) entries of the
// bucket memory, during which no item leaves the queue.
module symbol_intern_hash_table_top (
  input  logic        clk,
  input  logic        rst_n,
  sih_in_if.sink      in_ch,
  sih_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata
);
  import sih_pkg::*;

  logic [10:0] limit_r;
  logic        clearing;
  logic        fv, fr, qv, qr;
  logic [1:0]  ff, qf;
  logic [63:0] flo, fhi, fh, qlo, qhi, qh;
  logic [9:0]  fs, qs;

  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= LIMIT_W'(MAX_ENTRIES);
    else if (cfg_we) limit_r <= cfg_wdata;
  end

  sih_front u_front (.clk, .rst_n, .in_ch, .job_valid(fv), .job_ready(fr), .job_func(ff),
    .job_lo(flo), .job_hi(fhi), .job_sid(fs), .job_hash(fh));

  // one-entry queue
  logic q_full_r;
  logic [1:0] qf_r; logic [63:0] qlo_r, qhi_r, qh_r; logic [9:0] qs_r;
  assign fr = !q_full_r;
  assign qv = q_full_r;
  assign qf = qf_r; assign qlo = qlo_r; assign qhi = qhi_r; assign qh = qh_r; assign qs = qs_r;
  always_ff @(posedge clk) begin
    if (!rst_n) q_full_r <= 1'b0;
    else if (fv && fr) q_full_r <= 1'b1;
    else if (qv && qr) q_full_r <= 1'b0;
    if (fv && fr) begin
      qf_r <= ff; qlo_r <= flo; qhi_r <= fhi; qh_r <= fh; qs_r <= fs;
    end
  end

  sih_back u_back (
    .clk, .rst_n, .entry_limit(limit_r), .clearing, .job_valid(qv), .job_ready(qr),
    .job_func(qf), .job_lo(qlo), .job_hi(qhi), .job_sid(qs), .job_hash(qh), .out_ch);

`ifndef NO_ASSERTIONS
  a_q_clr: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !qr) else $error("queue drained during clear");
  a_q_hold: assert property (@(posedge clk) disable iff (!rst_n)
    q_full_r && !qr |=> q_full_r && $stable(qh_r)) else $error("queue entry lost");
  a_q_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    q_full_r |-> !fr) else $error("queue overwrite");
`endif
endmodule
